/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the link address field parser.
// Needs nothing else; files that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LAFP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LAFP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lafp_pkg.sv */
// Package of the link address field parser: codes, widths and structs.
// Depends on nothing; the parser, classifier, result register and testbench use it.
package lafp_pkg;

	localparam int MAX_DIGIPEATERS_DEF = 6;

	localparam int ADDR_LEN = 7;
	localparam logic [2:0] SSID_POS = 3'd6;
	localparam int SLOT_W = 4;
	localparam int DCNT_W = 4;
	localparam int MASK_W = 6;

	localparam int BIT_C = 7;
	localparam int BIT_REP = 7;
	localparam int BIT_E = 0;

	localparam logic [2:0] REG_DEST = 3'd0;
	localparam logic [2:0] REG_SRC = 3'd1;
	localparam logic [2:0] REG_DIGI = 3'd2;
	localparam logic [2:0] REG_PAYLOAD = 3'd3;
	localparam logic [2:0] REG_DISCARD = 3'd4;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_SHORT = 2'd1;
	localparam logic [1:0] ERR_TOO_MANY = 2'd2;

	localparam logic [1:0] CR_NONE = 2'd0;
	localparam logic [1:0] CR_CMD = 2'd1;
	localparam logic [1:0] CR_RESP = 2'd2;

	typedef enum logic [2:0] {
		PH_ADDR    = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_DISCARD = 3'b100
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [SLOT_W-1:0]   slot;
		logic [2:0]          pos;
		logic [DCNT_W-1:0]   digis;
		logic signed [3:0]   last_rep;
		logic [MASK_W-1:0]   rep_bits;
		logic [1:0]          cr_flag;
	} frame_state_t;

	localparam frame_state_t FRAME_STATE_RST = '{
		phase:    PH_ADDR,
		slot:     '0,
		pos:      '0,
		digis:    '0,
		last_rep: -4'sd1,
		rep_bits: '0,
		cr_flag:  CR_NONE
	};

	typedef struct packed {
		logic [7:0]        byte_out;
		logic [2:0]        region;
		logic [2:0]        address_slot;
		logic [2:0]        byte_in_address;
		logic              header_done;
		logic [1:0]        error_code;
		logic [1:0]        cmd_resp;
		logic [2:0]        digi_count;
		logic signed [3:0] last_repeated;
		logic [5:0]        repeated_mask;
		logic              frame_end;
	} result_t;

endpackage

/* rtl/lafp_if.sv */
// Channel interfaces of the link address field parser: byte input, tagged result output.
// Depends on nothing but plain logic types.
interface lafp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface lafp_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        byte_out;
	logic [2:0]        region;
	logic [2:0]        address_slot;
	logic [2:0]        byte_in_address;
	logic              header_done;
	logic [1:0]        error_code;
	logic [1:0]        cmd_resp;
	logic [2:0]        digi_count;
	logic signed [3:0] last_repeated;
	logic [5:0]        repeated_mask;
	logic              frame_end;

	modport source (output valid, output byte_out, output region, output address_slot,
		output byte_in_address, output header_done, output error_code, output cmd_resp,
		output digi_count, output last_repeated, output repeated_mask, output frame_end,
		input ready);
	modport sink (input valid, input byte_out, input region, input address_slot,
		input byte_in_address, input header_done, input error_code, input cmd_resp,
		input digi_count, input last_repeated, input repeated_mask, input frame_end,
		output ready);
endinterface

/* rtl/link_address_field_parser.sv */
// Link address field parser: tags each frame byte with its address region and position.
// A byte is held in the input stage, then its tag goes into the result register.
// Throughput: one byte per cycle, one classifier pass each, unless the receiver stalls.
// Reset (arst_n low, asynchronous): both stages empty, frame tracker at the start of a frame.
// Depends on lafp_pkg, lafp_if, lafp_classify, lafp_result_reg and assert_macros.svh.
`include "assert_macros.svh"

module link_address_field_parser #(
	parameter int MAX_DIGIPEATERS = lafp_pkg::MAX_DIGIPEATERS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lafp_in_if.sink     frame_bytes,
	lafp_out_if.source  tagged_bytes
);

	// Input stage: holds one request until the result register can take its result.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame tracker: position in the address field, digipeater record and C/R flag.
	// It advances only when the byte in the input stage moves on to the result register.
	lafp_pkg::frame_state_t state_q;
	lafp_pkg::frame_state_t state_nxt;

	lafp_pkg::result_t res_s1;
	lafp_pkg::result_t res_out;
	logic res_valid;
	logic res_free;
	logic adv_s1;

	assign adv_s1 = valid_s1 && res_free;

	// The input stage takes a new request whenever it is empty or its byte moves on.
	// A waiting result in the output register stops the flow only once the input
	// stage is also full, so two requests can be held while the receiver stalls.
	assign frame_bytes.ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_bytes.ready) begin
			valid_s1 <= frame_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_bytes.ready && frame_bytes.valid) begin
			byte_s1 <= frame_bytes.data_byte;
			last_s1 <= frame_bytes.frame_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lafp_pkg::FRAME_STATE_RST;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	lafp_classify #(
		.MAX_DIGIPEATERS(MAX_DIGIPEATERS)
	) u_classify (
		.data_byte  (byte_s1),
		.frame_last (last_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_s1)
	);

	lafp_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv_s1),
		.data_in  (res_s1),
		.take     (tagged_bytes.ready),
		.can_load (res_free),
		.valid    (res_valid),
		.data_out (res_out)
	);

	assign tagged_bytes.valid = res_valid;
	assign tagged_bytes.byte_out = res_out.byte_out;
	assign tagged_bytes.region = res_out.region;
	assign tagged_bytes.address_slot = res_out.address_slot;
	assign tagged_bytes.byte_in_address = res_out.byte_in_address;
	assign tagged_bytes.header_done = res_out.header_done;
	assign tagged_bytes.error_code = res_out.error_code;
	assign tagged_bytes.cmd_resp = res_out.cmd_resp;
	assign tagged_bytes.digi_count = res_out.digi_count;
	assign tagged_bytes.last_repeated = res_out.last_repeated;
	assign tagged_bytes.repeated_mask = res_out.repeated_mask;
	assign tagged_bytes.frame_end = res_out.frame_end;

	// Discarded bytes always carry the too-many-digipeaters error.
	`LAFP_ASSERT_IMP(a_discard_err, clk, arst_n,
		res_valid && res_out.region == lafp_pkg::REG_DISCARD,
		res_out.error_code == lafp_pkg::ERR_TOO_MANY,
		"discarded byte without too-many error")

	// The byte completing the address field is an error-free source or digipeater SSID byte.
	`LAFP_ASSERT_IMP(a_done_ok, clk, arst_n,
		res_valid && res_out.header_done,
		res_out.error_code == lafp_pkg::ERR_NONE &&
		res_out.byte_in_address == lafp_pkg::SSID_POS &&
		(res_out.region == lafp_pkg::REG_SRC || res_out.region == lafp_pkg::REG_DIGI),
		"header done on a wrong byte")

	// On a digipeater SSID byte the count equals that digipeater's number plus one.
	`LAFP_ASSERT_IMP(a_digi_count, clk, arst_n,
		res_valid && res_out.region == lafp_pkg::REG_DIGI &&
		res_out.byte_in_address == lafp_pkg::SSID_POS,
		res_out.digi_count == res_out.address_slot - 3'd1,
		"digipeater count out of step with slot")

	// The byte that ends a frame returns the tracker to the start of a frame.
	`LAFP_ASSERT_NXT(a_frame_clear, clk, arst_n,
		adv_s1 && last_s1,
		state_q == lafp_pkg::FRAME_STATE_RST,
		"frame state not cleared at frame end")

endmodule

/* rtl/lafp_classify.sv */
// Per-byte classification logic: tags one byte and computes the next frame state.
// Depends on lafp_pkg.
module lafp_classify #(
	parameter int MAX_DIGIPEATERS = lafp_pkg::MAX_DIGIPEATERS_DEF
) (
	input  logic [7:0]            data_byte,
	input  logic                  frame_last,
	input  lafp_pkg::frame_state_t cur,
	output lafp_pkg::frame_state_t nxt,
	output lafp_pkg::result_t     res
);

	localparam logic [lafp_pkg::DCNT_W-1:0] MAX_D = lafp_pkg::DCNT_W'(MAX_DIGIPEATERS);

	lafp_pkg::frame_state_t upd;
	logic [lafp_pkg::SLOT_W-1:0] d;
	logic [2:0] region;
	logic [2:0] slot_out;
	logic [2:0] pos_out;
	logic done;
	logic [1:0] err;

	assign d = cur.slot - lafp_pkg::SLOT_W'(2);

	always_comb begin
		upd = cur;
		region = lafp_pkg::REG_PAYLOAD;
		slot_out = '0;
		pos_out = '0;
		done = 1'b0;
		err = lafp_pkg::ERR_NONE;
		unique case (cur.phase)
			lafp_pkg::PH_ADDR: begin
				slot_out = cur.slot[2:0];
				pos_out = cur.pos;
				if (cur.slot == '0) begin
					region = lafp_pkg::REG_DEST;
				end else if (cur.slot == lafp_pkg::SLOT_W'(1)) begin
					region = lafp_pkg::REG_SRC;
				end else begin
					region = lafp_pkg::REG_DIGI;
				end
				if (cur.pos == lafp_pkg::SSID_POS) begin
					upd.pos = '0;
					upd.slot = cur.slot + lafp_pkg::SLOT_W'(1);
				end else begin
					upd.pos = cur.pos + 3'd1;
				end
				if (cur.pos == lafp_pkg::SSID_POS) begin
					if (cur.slot == '0) begin
						if (data_byte[lafp_pkg::BIT_C]) begin
							upd.cr_flag = lafp_pkg::CR_CMD;
						end
					end else begin
						if (cur.slot == lafp_pkg::SLOT_W'(1)) begin
							if (data_byte[lafp_pkg::BIT_C]) begin
								upd.cr_flag = lafp_pkg::CR_RESP;
							end
						end else begin
							upd.digis = d + lafp_pkg::DCNT_W'(1);
							if (data_byte[lafp_pkg::BIT_REP]) begin
								for (int i = 0; i < lafp_pkg::MASK_W; i++) begin
									if (d == lafp_pkg::SLOT_W'(i)) begin
										upd.rep_bits[i] = 1'b1;
									end
								end
								upd.last_rep = d;
							end
						end
						if (data_byte[lafp_pkg::BIT_E]) begin
							done = 1'b1;
							upd.phase = lafp_pkg::PH_PAYLOAD;
						end else if (upd.digis >= MAX_D) begin
							err = lafp_pkg::ERR_TOO_MANY;
							upd.phase = lafp_pkg::PH_DISCARD;
						end
					end
				end
				if (frame_last && !done && err == lafp_pkg::ERR_NONE) begin
					err = lafp_pkg::ERR_SHORT;
				end
			end
			lafp_pkg::PH_DISCARD: begin
				region = lafp_pkg::REG_DISCARD;
				err = lafp_pkg::ERR_TOO_MANY;
			end
			lafp_pkg::PH_PAYLOAD: begin
				region = lafp_pkg::REG_PAYLOAD;
			end
			default: begin
				region = lafp_pkg::REG_PAYLOAD;
			end
		endcase
	end

	always_comb begin
		res.byte_out = data_byte;
		res.region = region;
		res.address_slot = slot_out;
		res.byte_in_address = pos_out;
		res.header_done = done;
		res.error_code = err;
		res.cmd_resp = upd.cr_flag;
		res.digi_count = upd.digis[2:0];
		res.last_repeated = upd.last_rep;
		res.repeated_mask = upd.rep_bits;
		res.frame_end = frame_last;
	end

	// The byte that ends a frame leaves the tracker ready for a new frame.
	assign nxt = frame_last ? lafp_pkg::FRAME_STATE_RST : upd;

endmodule

/* rtl/lafp_result_reg.sv */
// Result register of the link address field parser, with its valid flag.
// Depends on lafp_pkg.
module lafp_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lafp_pkg::result_t data_in,
	input  logic              take,
	output logic              can_load,
	output logic              valid,
	output lafp_pkg::result_t data_out
);

	logic valid_q;
	lafp_pkg::result_t data_q;

	// Free when empty or when the held result leaves in this cycle.
	assign can_load = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_in;
		end
	end

	assign valid = valid_q;
	assign data_out = data_q;

endmodule

/* dv/link_address_field_parser_tb.sv */
// Self-checking testbench of the link address field parser: random and directed frames.
// Depends on lafp_pkg, lafp_in_if, lafp_out_if and the link_address_field_parser top level.
`timescale 1ns / 100ps

module link_address_field_parser_tb;

	// The block runs with its default digipeater limit.
	localparam int DIGI_LIMIT = lafp_pkg::MAX_DIGIPEATERS_DEF;
	// Receiver hold-off used to back the block up into its input.
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lafp_in_if  in_ch ();
	lafp_out_if out_ch ();

	link_address_field_parser #(
		.MAX_DIGIPEATERS(DIGI_LIMIT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_bytes  (in_ch),
		.tagged_bytes (out_ch)
	);

	always #10 clk = ~clk;

	// Byte requests waiting to be offered, and tags expected back, oldest first.
	byte_req_t pending_bytes[$];
	lafp_pkg::result_t expected_tags[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int queued_count = 0;
	int mismatch_count = 0;
	logic in_taken = 1'b0;

	// Frame tracker of the prediction, mirroring the block's per-frame state.
	logic [5:0]        trk_pos;
	lafp_pkg::phase_t  trk_phase;
	logic [2:0]        trk_digis;
	logic signed [3:0] trk_last_rep;
	logic [5:0]        trk_rep_mask;
	logic [1:0]        trk_cr;

	function automatic void clear_tracker();
		trk_pos = '0;
		trk_phase = lafp_pkg::PH_ADDR;
		trk_digis = '0;
		trk_last_rep = -4'sd1;
		trk_rep_mask = '0;
		trk_cr = lafp_pkg::CR_NONE;
	endfunction

	// Works out the tag of one accepted byte and advances the frame tracker.
	// Bytes of the address field are counted from the start of the frame;
	// the SSID byte (position 6) of each address carries the C, repeated and
	// extension bits that drive the flags, the count and the end of the field.
	function automatic lafp_pkg::result_t tag_frame_byte(input logic [7:0] b, input logic last);
		lafp_pkg::result_t r;
		int slot_n;
		int pos_n;
		int d;
		r = '0;
		r.byte_out = b;
		r.region = lafp_pkg::REG_PAYLOAD;
		r.error_code = lafp_pkg::ERR_NONE;
		if (trk_phase == lafp_pkg::PH_ADDR) begin
			slot_n = trk_pos / lafp_pkg::ADDR_LEN;
			pos_n = trk_pos % lafp_pkg::ADDR_LEN;
			r.address_slot = slot_n[2:0];
			r.byte_in_address = pos_n[2:0];
			r.region = (slot_n == 0) ? lafp_pkg::REG_DEST :
				((slot_n == 1) ? lafp_pkg::REG_SRC : lafp_pkg::REG_DIGI);
			trk_pos = trk_pos + 6'd1;
			if (pos_n == lafp_pkg::SSID_POS) begin
				if (slot_n == 0) begin
					// The destination's C bit marks a command; its extension bit is ignored.
					if (b[lafp_pkg::BIT_C])
						trk_cr = lafp_pkg::CR_CMD;
				end else begin
					if (slot_n == 1) begin
						// The source's C bit marks a response, which wins over a command.
						if (b[lafp_pkg::BIT_C])
							trk_cr = lafp_pkg::CR_RESP;
					end else begin
						d = slot_n - 2;
						trk_digis = d[2:0] + 3'd1;
						if (b[lafp_pkg::BIT_REP]) begin
							if (d < lafp_pkg::MASK_W)
								trk_rep_mask[d] = 1'b1;
							trk_last_rep = d[3:0];
						end
					end
					if (b[lafp_pkg::BIT_E]) begin
						r.header_done = 1'b1;
						trk_phase = lafp_pkg::PH_PAYLOAD;
					end else if (int'(trk_digis) >= DIGI_LIMIT) begin
						// Too many digipeaters; the rest of the frame is thrown away.
						r.error_code = lafp_pkg::ERR_TOO_MANY;
						trk_phase = lafp_pkg::PH_DISCARD;
					end
				end
			end
			// The frame ended inside the address field.
			if (last && !r.header_done && r.error_code == lafp_pkg::ERR_NONE)
				r.error_code = lafp_pkg::ERR_SHORT;
		end else if (trk_phase == lafp_pkg::PH_DISCARD) begin
			r.region = lafp_pkg::REG_DISCARD;
			r.error_code = lafp_pkg::ERR_TOO_MANY;
		end
		r.cmd_resp = trk_cr;
		r.digi_count = trk_digis;
		r.last_repeated = trk_last_rep;
		r.repeated_mask = trk_rep_mask;
		r.frame_end = last;
		// The byte after the end mark starts a new frame.
		if (last)
			clear_tracker();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
		input logic signed [31:0] want);
		mismatch_count++;
		$display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic check_tags(input lafp_pkg::result_t got, input lafp_pkg::result_t want);
		if (got.byte_out !== want.byte_out)
			report_mismatch("byte_out", got.byte_out, want.byte_out);
		if (got.region !== want.region)
			report_mismatch("region", got.region, want.region);
		if (got.address_slot !== want.address_slot)
			report_mismatch("address_slot", got.address_slot, want.address_slot);
		if (got.byte_in_address !== want.byte_in_address)
			report_mismatch("byte_in_address", got.byte_in_address, want.byte_in_address);
		if (got.header_done !== want.header_done)
			report_mismatch("header_done", got.header_done, want.header_done);
		if (got.error_code !== want.error_code)
			report_mismatch("error_code", got.error_code, want.error_code);
		if (got.cmd_resp !== want.cmd_resp)
			report_mismatch("cmd_resp", got.cmd_resp, want.cmd_resp);
		if (got.digi_count !== want.digi_count)
			report_mismatch("digi_count", got.digi_count, want.digi_count);
		if (got.last_repeated !== want.last_repeated)
			report_mismatch("last_repeated", got.last_repeated, want.last_repeated);
		if (got.repeated_mask !== want.repeated_mask)
			report_mismatch("repeated_mask", got.repeated_mask, want.repeated_mask);
		if (got.frame_end !== want.frame_end)
			report_mismatch("frame_end", got.frame_end, want.frame_end);
	endtask

	task automatic push_request(input logic [7:0] b, input logic last);
		byte_req_t req;
		req.data = b;
		req.last = last;
		pending_bytes.push_back(req);
		queued_count++;
	endtask

	// Queues one frame: destination, source and n_digis digipeater addresses with
	// random content, then payload. With close_field set the last address carries
	// the extension bit; without it the field runs on (six digipeaters then give
	// the too-many error). A nonzero cut_len truncates the frame to that length.
	task automatic queue_frame(input int n_digis, input bit close_field, input int payload_len,
		input int cut_len);
		logic [7:0] fb[$];
		logic [7:0] ssid;
		int n_addr;
		int a;
		int k;
		n_addr = 2 + n_digis;
		for (a = 0; a < n_addr; a++) begin
			for (k = 0; k < lafp_pkg::ADDR_LEN - 1; k++)
				fb.push_back(8'($urandom_range(255)));
			ssid = 8'($urandom_range(255));
			if (a > 0)
				ssid[lafp_pkg::BIT_E] = close_field && (a == n_addr - 1);
			fb.push_back(ssid);
		end
		for (k = 0; k < payload_len; k++)
			fb.push_back(8'($urandom_range(255)));
		if (cut_len > 0 && cut_len < fb.size())
			fb = fb[0:cut_len-1];
		for (k = 0; k < fb.size(); k++)
			push_request(fb[k], k == fb.size() - 1);
	endtask

	// Mostly well-formed frames; the rest are too-many frames, frames cut short
	// inside the address field, and bursts of raw noise.
	task automatic queue_random_frame();
		int kind;
		int n;
		int len;
		int k;
		kind = $urandom_range(99);
		n = $urandom_range(DIGI_LIMIT);
		if (kind < 70) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
			queue_frame(n, 1'b1, len, 0);
		end else if (kind < 80) begin
			queue_frame(DIGI_LIMIT, 1'b0, $urandom_range(10), 0);
		end else if (kind < 90) begin
			queue_frame(n, 1'b1, 0,
				$urandom_range(2 * lafp_pkg::ADDR_LEN + lafp_pkg::ADDR_LEN * n - 1, 1));
		end else begin
			len = $urandom_range(30, 1);
			for (k = 0; k < len; k++)
				push_request(8'($urandom_range(255)), (k == len - 1) || ($urandom_range(15) == 0));
		end
	endtask

	// Sender pause: nothing more is offered until every expected tag has come back.
	task automatic drain_all();
		while (pending_bytes.size() != 0 || in_ch.valid === 1'b1 || expected_tags.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
		int stop_at;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at = queued_count + n_items;
		while (queued_count < stop_at)
			queue_random_frame();
		drain_all();
	endtask

	// Driver: a new request goes up at the falling edge once the previous one
	// was taken, or after an idle cycle; the idle chance is drawn per cycle.
	always @(negedge clk) begin : drive_requests
		byte_req_t nxt;
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_bytes.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.data_byte <= nxt.data;
					in_ch.frame_last <= nxt.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever the control flow
	// asks for one; the hold-off is counted down here, one cycle at a time.
	always @(negedge clk) begin : drive_ready
		int hold_seen;
		int hold_left;
		if (arst_n) begin
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Monitor: at each rising edge, an accepted tag is checked against the oldest
	// expectation, and an accepted request adds its prediction. A request cannot
	// come out at the edge that takes it, so the order of the two does not matter.
	always @(posedge clk) begin : watch_channels
		lafp_pkg::result_t got;
		if (arst_n) begin
			in_taken <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.byte_out = out_ch.byte_out;
				got.region = out_ch.region;
				got.address_slot = out_ch.address_slot;
				got.byte_in_address = out_ch.byte_in_address;
				got.header_done = out_ch.header_done;
				got.error_code = out_ch.error_code;
				got.cmd_resp = out_ch.cmd_resp;
				got.digi_count = out_ch.digi_count;
				got.last_repeated = out_ch.last_repeated;
				got.repeated_mask = out_ch.repeated_mask;
				got.frame_end = out_ch.frame_end;
				if (expected_tags.size() == 0)
					report_mismatch("tag with none expected, byte", got.byte_out, 0);
				else
					check_tags(got, expected_tags.pop_front());
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				expected_tags.push_back(tag_frame_byte(in_ch.data_byte, in_ch.frame_last));
		end
	end

	initial begin : run_limit
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : control
		int k;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.frame_last = 1'b0;
		out_ch.ready = 1'b0;
		clear_tracker();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. One-byte frames with the byte extremes: both end short
		// on the first destination byte.
		push_request(8'hFF, 1'b1);
		push_request(8'h00, 1'b1);
		// Shortest valid field: the destination's C bit and ignored extension bit,
		// then a source with C and extension set, so response wins; two payload bytes.
		for (k = 0; k < lafp_pkg::ADDR_LEN - 1; k++)
			push_request(8'h00, 1'b0);
		push_request(8'hFF, 1'b0);
		for (k = 0; k < lafp_pkg::ADDR_LEN - 1; k++)
			push_request(8'hFF, 1'b0);
		push_request(8'h81, 1'b0);
		push_request(8'h00, 1'b0);
		push_request(8'hFF, 1'b1);
		// Frame that ends on the destination's SSID byte: command seen, short frame.
		for (k = 0; k < lafp_pkg::ADDR_LEN - 1; k++)
			push_request(8'h55, 1'b0);
		push_request(8'h80, 1'b1);
		drain_all();

		// No idling and a long receiver hold-off while requests keep coming, so the block backs
		// up and stalls its input; then sender idling, receiver stalls, and both together.
		hold_seq++;
		run_phase(0, 0, 400);
		run_phase(70, 0, 400);
		run_phase(0, 70, 400);
		run_phase(32, 32, 400);

		// Let the pipeline settle so that any stray tag shows up.
		repeat (10) @(posedge clk);
		if (expected_tags.size() != 0)
			report_mismatch("tags never delivered", expected_tags.size(), 0);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* link_address_field_parser.f */
+incdir+rtl
rtl/lafp_pkg.sv
rtl/lafp_if.sv
rtl/lafp_classify.sv
rtl/lafp_result_reg.sv
rtl/link_address_field_parser.sv
dv/link_address_field_parser_tb.sv
